>>> sv/nru_pkg.sv
package nru_pkg;

  localparam int TableEntries = 256;
  localparam int SeedNum      = 523520;
  localparam int MulStages    = 3;

  typedef logic [63:0] word_t;

  // Command codes
  typedef enum logic {
    CMD_ONE_WORD = 1'b0,
    CMD_TWO_WORD = 1'b1
  } cmd_t;

  // Item context carried through the pipeline
  typedef struct packed {
    logic  cmd;
    logic  bad;
    word_t d1;
    word_t d0;
  } ctx_t;

endpackage

>>> sv/nru_mul64.sv
// 64x64 multiply in three register stages: four 32x32 partial products,
// then two accumulation steps. Carries a context tag alongside.
module nru_mul64 (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  input  logic [191:0]        tag_in,
  output logic                out_valid,
  output logic [127:0]        prod,
  output logic [191:0]        tag_out
);

  logic [63:0]  p00, p01, p10, p11;
  logic [191:0] tag1, tag2;
  logic         v1, v2;
  logic [127:0] part_lo, part_hi;

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p00  <= 64'(a[31:0])  * 64'(b[31:0]);
      p01  <= 64'(a[31:0])  * 64'(b[63:32]);
      p10  <= 64'(a[63:32]) * 64'(b[31:0]);
      p11  <= 64'(a[63:32]) * 64'(b[63:32]);
      tag1 <= tag_in;
    end
  end

  // Stage 2: sum outer and cross terms separately
  always_ff @(posedge clk) begin
    if (en) begin
      part_lo <= {p11, p00};
      part_hi <= {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0};
      tag2    <= tag1;
    end
  end

  // Stage 3: final add
  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= part_lo + part_hi;
      tag_out <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

endmodule

>>> sv/nru_core.sv
// Reciprocal datapath: seed, two Newton steps, exact correction and the
// two-word adjustment, as a chain of pipelined 64-bit multipliers.
// The whole pipe advances when en is high.
module nru_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  nru_pkg::ctx_t in_ctx,
  output logic          out_valid,
  output logic          out_bad,
  output nru_pkg::word_t out_recip
);

  // tag layout: {v(64), ctx(130 trimmed into 128+2)} -> use 192 bits:
  // [191:128] working value, [127:64] d1, [63:0] d0. cmd/bad travel aside.
  localparam int Lat = nru_pkg::MulStages;

  // Side channel for cmd/bad through each multiplier: small shift lines
  typedef struct packed {
    logic cmd;
    logic bad;
  } flg_t;

  // Seed table: floor(SeedNum / d9) for d9 = 256..511, folded at elaboration
  logic [10:0] seed_rom [nru_pkg::TableEntries];
  for (genvar g = 0; g < nru_pkg::TableEntries; g++) begin : g_seed
    localparam int SeedVal = nru_pkg::SeedNum / (g + nru_pkg::TableEntries);
    assign seed_rom[g] = 11'(SeedVal);
  end

  // ---------------- Seed stage ----------------
  logic        s0_valid;
  flg_t        s0_flg;
  logic [63:0] s0_d1, s0_d0;
  logic [10:0] s0_v0;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_flg <= '{cmd: in_ctx.cmd, bad: in_ctx.bad};
      s0_d1  <= in_ctx.d1;
      s0_d0  <= in_ctx.d0;
      s0_v0  <= seed_rom[in_ctx.d1[62:55]];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (en) s0_valid <= in_valid;
  end

  // ---------------- Newton step 1 ----------------
  // v1 = (v0<<11) - ((v0*v0*d40)>>40) - 1 ; v0*v0 22 bits, d40 41 bits
  logic [63:0] s0_d40;
  assign s0_d40 = (s0_d1 >> 24) + 64'd1;

  logic [21:0] s1_sq;
  logic [63:0] s1_d1, s1_d0, s1_d40;
  logic [10:0] s1_v0;
  flg_t        s1_flg;
  logic        s1_valid;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sq  <= 22'(s0_v0) * 22'(s0_v0);
      s1_v0  <= s0_v0;
      s1_d1  <= s0_d1;
      s1_d0  <= s0_d0;
      s1_d40 <= s0_d40;
      s1_flg <= s0_flg;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= s0_valid;
  end

  // m1: v0^2 * d40
  logic        m1_ov;
  logic [127:0] m1_p;
  logic [191:0] m1_t;
  nru_mul64 u_m1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s1_valid),
    .a({42'd0, s1_sq}), .b(s1_d40),
    .tag_in({53'd0, s1_v0, s1_d1, s1_d0}),
    .out_valid(m1_ov), .prod(m1_p), .tag_out(m1_t)
  );

  // flags and d40 travel by shift lines of the multiplier latency
  flg_t        f1 [Lat];
  logic [63:0] d40_l [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      f1[0] <= s1_flg;
      d40_l[0] <= s1_d40;
      for (int i = 1; i < Lat; i++) begin
        f1[i] <= f1[i-1];
        d40_l[i] <= d40_l[i-1];
      end
    end
  end

  logic [63:0] s2_v1, s2_d1, s2_d0, s2_d40;
  flg_t        s2_flg;
  logic        s2_valid;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_v1  <= ({53'd0, m1_t[138:128]} << 11) - (m1_p[103:40]) - 64'd1;
      s2_d1  <= m1_t[127:64];
      s2_d0  <= m1_t[63:0];
      s2_d40 <= d40_l[Lat-1];
      s2_flg <= f1[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= m1_ov;
  end

  // ---------------- Newton step 2 ----------------
  // t = 2^60 - v1*d40 ; v2 = (v1<<13) + ((v1*t)>>47), products kept to 64 bits
  logic        m2_ov;
  logic [127:0] m2_p;
  logic [191:0] m2_t;
  nru_mul64 u_m2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s2_valid),
    .a(s2_v1), .b(s2_d40), .tag_in({s2_v1, s2_d1, s2_d0}),
    .out_valid(m2_ov), .prod(m2_p), .tag_out(m2_t)
  );
  flg_t f2 [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      f2[0] <= s2_flg;
      for (int i = 1; i < Lat; i++) f2[i] <= f2[i-1];
    end
  end

  logic [63:0] s3_t, s3_v1, s3_d1, s3_d0;
  flg_t        s3_flg;
  logic        s3_valid;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_t   <= (64'd1 << 60) - m2_p[63:0];
      s3_v1  <= m2_t[191:128];
      s3_d1  <= m2_t[127:64];
      s3_d0  <= m2_t[63:0];
      s3_flg <= f2[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= m2_ov;
  end

  logic        m3_ov;
  logic [127:0] m3_p;
  logic [191:0] m3_t;
  nru_mul64 u_m3 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s3_valid),
    .a(s3_v1), .b(s3_t), .tag_in({s3_v1, s3_d1, s3_d0}),
    .out_valid(m3_ov), .prod(m3_p), .tag_out(m3_t)
  );
  flg_t f3 [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      f3[0] <= s3_flg;
      for (int i = 1; i < Lat; i++) f3[i] <= f3[i-1];
    end
  end

  logic [63:0] s4_v2, s4_d1, s4_d0;
  flg_t        s4_flg;
  logic        s4_valid;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_v2  <= (m3_t[191:128] << 13) + {47'd0, m3_p[63:47]};
      s4_d1  <= m3_t[127:64];
      s4_d0  <= m3_t[63:0];
      s4_flg <= f3[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en) s4_valid <= m3_ov;
  end

  // ---------------- Correction ----------------
  // e = ((v2>>1)&odd) - lo(v2*d63)
  logic [63:0] s4_d63;
  assign s4_d63 = (s4_d1 >> 1) + {63'd0, s4_d1[0]};

  logic        m4_ov;
  logic [127:0] m4_p;
  logic [191:0] m4_t;
  nru_mul64 u_m4 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s4_valid),
    .a(s4_v2), .b(s4_d63), .tag_in({s4_v2, s4_d1, s4_d0}),
    .out_valid(m4_ov), .prod(m4_p), .tag_out(m4_t)
  );
  flg_t f4 [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      f4[0] <= s4_flg;
      for (int i = 1; i < Lat; i++) f4[i] <= f4[i-1];
    end
  end

  logic [63:0] s5_e, s5_v2, s5_d1, s5_d0;
  flg_t        s5_flg;
  logic        s5_valid;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_e   <= ((m4_t[191:128] >> 1) & {64{m4_t[64]}}) - m4_p[63:0];
      s5_v2  <= m4_t[191:128];
      s5_d1  <= m4_t[127:64];
      s5_d0  <= m4_t[63:0];
      s5_flg <= f4[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else if (en) s5_valid <= m4_ov;
  end

  logic        m5_ov;
  logic [127:0] m5_p;
  logic [191:0] m5_t;
  nru_mul64 u_m5 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s5_valid),
    .a(s5_e), .b(s5_v2), .tag_in({s5_v2, s5_d1, s5_d0}),
    .out_valid(m5_ov), .prod(m5_p), .tag_out(m5_t)
  );
  flg_t f5 [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      f5[0] <= s5_flg;
      for (int i = 1; i < Lat; i++) f5[i] <= f5[i-1];
    end
  end

  // v3 = (v2<<31) + (hi>>1)
  logic [63:0] s6_v3, s6_d1, s6_d0;
  flg_t        s6_flg;
  logic        s6_valid;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_v3  <= (m5_t[191:128] << 31) + {1'b0, m5_p[127:65]};
      s6_d1  <= m5_t[127:64];
      s6_d0  <= m5_t[63:0];
      s6_flg <= f5[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s6_valid <= 1'b0;
    else if (en) s6_valid <= m5_ov;
  end

  // hi((v3+1)*d); when v3 is all ones the product is 2^64*d, hi = d,
  // which the multiply by (v3+1)=0 misses, so patch afterward.
  logic        m6_ov;
  logic [127:0] m6_p;
  logic [191:0] m6_t;
  nru_mul64 u_m6 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s6_valid),
    .a(s6_v3 + 64'd1), .b(s6_d1), .tag_in({s6_v3, s6_d1, s6_d0}),
    .out_valid(m6_ov), .prod(m6_p), .tag_out(m6_t)
  );
  flg_t f6 [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      f6[0] <= s6_flg;
      for (int i = 1; i < Lat; i++) f6[i] <= f6[i-1];
    end
  end

  logic [63:0] s7_hi_fix;
  assign s7_hi_fix = (m6_t[191:128] == '1) ? m6_t[127:64] : m6_p[127:64];

  logic [63:0] s7_v, s7_d1, s7_d0;
  flg_t        s7_flg;
  logic        s7_valid;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_v   <= m6_t[191:128] - s7_hi_fix - m6_t[127:64];
      s7_d1  <= m6_t[127:64];
      s7_d0  <= m6_t[63:0];
      s7_flg <= f6[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s7_valid <= 1'b0;
    else if (en) s7_valid <= m6_ov;
  end

  // ---------------- Two-word adjustment ----------------
  // p = lo(v*d1) + d0 with carry-driven decrements
  logic        m7_ov;
  logic [127:0] m7_p;
  logic [191:0] m7_t;
  nru_mul64 u_m7 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s7_valid),
    .a(s7_v), .b(s7_d1), .tag_in({s7_v, s7_d1, s7_d0}),
    .out_valid(m7_ov), .prod(m7_p), .tag_out(m7_t)
  );
  flg_t f7 [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      f7[0] <= s7_flg;
      for (int i = 1; i < Lat; i++) f7[i] <= f7[i-1];
    end
  end

  logic [64:0] a_sum;
  logic [63:0] a_p, a_v, a_d1;
  always_comb begin
    a_d1  = m7_t[127:64];
    a_sum = {1'b0, m7_p[63:0]} + {1'b0, m7_t[63:0]};
    a_p   = a_sum[63:0];
    a_v   = m7_t[191:128];
    if (a_sum[64]) begin
      a_v = a_v - 64'd1;
      if (a_p >= a_d1) begin
        a_v = a_v - 64'd1;
        a_p = a_p - a_d1;
      end
      a_p = a_p - a_d1;
    end
  end

  logic [63:0] s8_v1w, s8_v, s8_p, s8_d1, s8_d0;
  flg_t        s8_flg;
  logic        s8_valid;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_v1w <= m7_t[191:128];
      s8_v   <= a_v;
      s8_p   <= a_p;
      s8_d1  <= a_d1;
      s8_d0  <= m7_t[63:0];
      s8_flg <= f7[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s8_valid <= 1'b0;
    else if (en) s8_valid <= m7_ov;
  end

  // t = v*d0 ; p carries in the tag's d1 word, d1 by a shift line
  logic        m8_ov;
  logic [127:0] m8_p;
  logic [191:0] m8_t;
  nru_mul64 u_m8 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s8_valid),
    .a(s8_v), .b(s8_d0), .tag_in({s8_v, s8_p, s8_d0}),
    .out_valid(m8_ov), .prod(m8_p), .tag_out(m8_t)
  );
  flg_t        f8 [Lat];
  logic [63:0] d1_l [Lat];
  logic [63:0] v1w_l [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      f8[0]    <= s8_flg;
      d1_l[0]  <= s8_d1;
      v1w_l[0] <= s8_v1w;
      for (int i = 1; i < Lat; i++) begin
        f8[i]    <= f8[i-1];
        d1_l[i]  <= d1_l[i-1];
        v1w_l[i] <= v1w_l[i-1];
      end
    end
  end

  logic [64:0] b_sum;
  logic [63:0] b_v, b_p, b_t0, b_t1, b_d0, b_d1;
  always_comb begin
    b_t1  = m8_p[127:64];
    b_t0  = m8_p[63:0];
    b_d0  = m8_t[63:0];
    b_d1  = d1_l[Lat-1];
    b_sum = {1'b0, m8_t[127:64]} + {1'b0, b_t1};
    b_p   = b_sum[63:0];
    b_v   = m8_t[191:128];
    if (b_sum[64]) begin
      b_v = b_v - 64'd1;
      if (b_p > b_d1 || (b_p == b_d1 && b_t0 >= b_d0)) b_v = b_v - 64'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_bad <= f8[Lat-1].bad;
      if (f8[Lat-1].bad) out_recip <= '0;
      else if (f8[Lat-1].cmd == nru_pkg::CMD_TWO_WORD) out_recip <= b_v;
      else out_recip <= v1w_l[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= m8_ov;
  end

endmodule

>>> sv/normalized_reciprocal_unit.sv
// Normalized reciprocal unit.
// Slave channel s_axis: tdata carries {divisor_low, divisor_high}, tuser the cmd
// (0 one-word reciprocal of divisor_high, 1 two-word reciprocal of both words).
// Master channel m_axis: tdata carries the 64-bit reciprocal, tuser the
// not_normalized flag (set when bit 63 of divisor_high is clear; result 0).
// Datapath: eight pipelined 64x64 multipliers of three stages each, with
// the seed, Newton and correction stages between them.
// Throughput: one item per cycle while the pipe is not stalled.
// Stall: the pipe holds as a whole while m_axis_tready is low and the output
// is occupied; s_axis_tready follows that same enable, so nothing is lost.
// Reset (rst, synchronous) clears all valid bits; the pipe starts empty.
module normalized_reciprocal_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,  // [63:0] divisor_high, [127:64] divisor_low
  input  logic          s_axis_tuser,  // [0] cmd
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,  // [63:0] reciprocal
  output logic          m_axis_tuser   // [0] not_normalized
);

  logic          en;
  nru_pkg::ctx_t ctx;

  // Pipe advances whenever the output slot is free or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    ctx.cmd = s_axis_tuser;
    ctx.bad = !s_axis_tdata[63];
    ctx.d1  = s_axis_tdata[63:0];
    ctx.d0  = s_axis_tdata[127:64];
  end

  nru_core u_core (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_axis_tvalid),
    .in_ctx(ctx),
    .out_valid(m_axis_tvalid),
    .out_bad(m_axis_tuser),
    .out_recip(m_axis_tdata)
  );

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // Input is taken exactly when the pipe moves
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready out of step with pipe enable");

  // Unnormalized results are zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero result for unnormalized divisor");

endmodule
